// ===== sv/ax25t_pkg.sv =====
// shared types and constants for the ax.25 to tnc2 text converter
package ax25t_pkg;

  localparam int MaxDigis = 8;
  localparam int CntW = $clog2(MaxDigis + 1);

  localparam logic [7:0] CtrlUi  = 8'h03;
  localparam logic [7:0] PidNone = 8'hf0;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;

  // work kinds handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_NONE,     // nothing to emit, just maybe frame end
    OP_SRC,      // source complete: emit src '>' dest
    OP_DIGI,     // emit ',' and digi text
    OP_CHAR,     // emit one character
    OP_CR_CHAR,  // emit cr then character
    OP_CR        // emit cr only
  } op_t;

  // one queued command
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       last;     // frame end marker follows
    logic       err;      // frame in error
    logic       end_cr;   // pending cr emitted before end marker
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);

endpackage

// ===== sv/ax25t_ram.sv =====
// generic single port write, single port registered read ram
module ax25t_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ax25t_front.sv =====
// front end: parses frame bytes, builds address text and queues commands
module ax25t_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_frame_byte,
  input  logic                 in_frame_end,
  output logic                 cmd_valid,
  input  logic                 cmd_stall,
  output ax25t_pkg::cmd_t      cmd,
  // address text store, one bank for current address, one for dest
  output logic                 txt_we,
  output logic [4:0]           txt_waddr,
  output logic [7:0]           txt_wdata,
  output logic [3:0]           cur_len,
  output logic [3:0]           dest_len
);

  typedef enum logic [2:0] {
    PH_DEST, PH_SRC, PH_DIGI, PH_CTRL, PH_PID, PH_PAYLOAD, PH_SKIP
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [2:0] alen_r, alen_nxt;
  logic       stopped_r, stopped_nxt;
  logic [3:0] dlen_r, dlen_nxt;
  logic [3:0] curlen_r, curlen_nxt;
  logic [ax25t_pkg::CntW-1:0] digi_r, digi_nxt;
  logic       cut_r, cut_nxt;
  logic       crp_r, crp_nxt;
  logic       err_r, err_nxt;
  logic       bank_r, bank_nxt;    // which half holds dest text

  // ssid suffix writes are done by a small finishing sequencer
  logic [1:0] sfx_cnt_r, sfx_cnt_nxt;
  logic [7:0] sfx_ch [3];
  logic [1:0] sfx_n;

  logic       busy_r, busy_nxt;   // writing suffix chars
  logic [7:0] ssid_r, ssid_nxt;
  logic       fin_r, fin_nxt;     // frame end pending after suffix
  phase_t     aph_r, aph_nxt;     // phase of address being finished
  logic       star_r, star_nxt;   // heard marker already written

  logic       acc;
  logic [7:0] c;
  logic [3:0] ssid;
  logic [ax25t_pkg::CntW-1:0] dcnt;

  assign acc = in_valid && !in_stall;
  assign in_stall = busy_r || cmd_stall;
  assign c = {1'b0, in_frame_byte[7:1]};

  assign ssid = ssid_r[4:1];
  always_comb begin
    sfx_ch[0] = ax25t_pkg::ChDash;
    sfx_ch[1] = (ssid >= 4'd10) ? 8'h31 : ax25t_pkg::ChZero + {4'd0, ssid};
    sfx_ch[2] = ax25t_pkg::ChZero + {4'd0, ssid - 4'd10};
    sfx_ch[2] = (ssid >= 4'd10) ? sfx_ch[2] : ax25t_pkg::ChStar;
    if (ssid == 4'd0) sfx_n = 2'd0;
    else if (ssid >= 4'd10) sfx_n = 2'd3;
    else sfx_n = 2'd2;
  end

  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; alen_nxt = alen_r;
    stopped_nxt = stopped_r; dlen_nxt = dlen_r; curlen_nxt = curlen_r;
    digi_nxt = digi_r; cut_nxt = cut_r; crp_nxt = crp_r; err_nxt = err_r;
    bank_nxt = bank_r; sfx_cnt_nxt = sfx_cnt_r; busy_nxt = busy_r;
    ssid_nxt = ssid_r; fin_nxt = fin_r; aph_nxt = aph_r; star_nxt = star_r;
    cmd_valid = 1'b0;
    cmd = '0;
    cmd.op = ax25t_pkg::OP_NONE;
    txt_we = 1'b0; txt_waddr = '0; txt_wdata = '0;
    dcnt = digi_r + 1'b1;

    if (busy_r) begin
      // write suffix characters and, for a digi, the heard marker into current bank, then finish
      if (sfx_cnt_r < sfx_n) begin
        txt_we = 1'b1;
        txt_waddr = {bank_r ^ (aph_r != PH_DEST), curlen_r};
        txt_wdata = sfx_ch[sfx_cnt_r];
        curlen_nxt = curlen_r + 1'b1;
        sfx_cnt_nxt = sfx_cnt_r + 1'b1;
      end else if (aph_r == PH_DIGI && ssid_r[7] && !star_r) begin
        txt_we = 1'b1;
        txt_waddr = {~bank_r, curlen_r};
        txt_wdata = ax25t_pkg::ChStar;
        curlen_nxt = curlen_r + 1'b1;
        star_nxt = 1'b1;
      end else if (!cmd_stall) begin
        busy_nxt = 1'b0;
        sfx_cnt_nxt = 2'd0;
        star_nxt = 1'b0;
        alen_nxt = '0; stopped_nxt = 1'b0;
        cmd.last = fin_r;
        case (aph_r)
          PH_DEST: begin
            dlen_nxt = curlen_r;
            curlen_nxt = '0;
            if (ssid_r[0]) begin
              err_nxt = 1'b1; phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_SRC;
            end
          end
          PH_SRC: begin
            cmd.op = ax25t_pkg::OP_SRC;
            phase_nxt = ssid_r[0] ? PH_CTRL : PH_DIGI;
          end
          default: begin
            digi_nxt = dcnt;
            if (dcnt >= ax25t_pkg::CntW'(ax25t_pkg::MaxDigis)) begin
              err_nxt = 1'b1; phase_nxt = PH_SKIP;
            end else begin
              if (dcnt == ax25t_pkg::CntW'(1) || (!cut_r && curlen_r != 4'd0))
                cmd.op = ax25t_pkg::OP_DIGI;
              else if (curlen_r == 4'd0)
                cut_nxt = 1'b1;
              if (ssid_r[0]) phase_nxt = PH_CTRL;
            end
          end
        endcase
        if (fin_r) begin
          if (phase_nxt != PH_PAYLOAD && phase_nxt != PH_SKIP) err_nxt = 1'b1;
          cmd.err = err_nxt;
          cmd_valid = 1'b1;
        end else begin
          cmd_valid = (cmd.op != ax25t_pkg::OP_NONE);
        end
        cmd.ch = '0;
      end
    end else if (acc) begin
      case (phase_r)
        PH_DEST, PH_SRC, PH_DIGI: begin
          if (pos_r < 3'd6) begin
            if (!stopped_r) begin
              if (c == ax25t_pkg::ChSpace || c == ax25t_pkg::ChStar)
                stopped_nxt = 1'b1;
              else begin
                txt_we = 1'b1;
                txt_waddr = {bank_r ^ (phase_r != PH_DEST), 1'b0, alen_r};
                txt_wdata = c;
                alen_nxt = alen_r + 1'b1;
              end
            end
            pos_nxt = pos_r + 1'b1;
          end else begin
            pos_nxt = '0;
            busy_nxt = 1'b1;
            ssid_nxt = in_frame_byte;
            fin_nxt = in_frame_end;
            aph_nxt = phase_r;
            curlen_nxt = {1'b0, alen_r};
            sfx_cnt_nxt = 2'd0;
            star_nxt = 1'b0;
          end
        end
        PH_CTRL: begin
          if (in_frame_byte == ax25t_pkg::CtrlUi) phase_nxt = PH_PID;
          else begin
            err_nxt = 1'b1; phase_nxt = PH_SKIP;
          end
        end
        PH_PID: begin
          if (in_frame_byte == ax25t_pkg::PidNone) begin
            cmd.op = ax25t_pkg::OP_CHAR;
            cmd.ch = ax25t_pkg::ChColon;
            phase_nxt = PH_PAYLOAD;
          end else begin
            err_nxt = 1'b1; phase_nxt = PH_SKIP;
          end
        end
        PH_PAYLOAD: begin
          if (in_frame_byte == ax25t_pkg::ChLf) begin
            crp_nxt = 1'b0; phase_nxt = PH_SKIP;
          end else begin
            crp_nxt = (in_frame_byte == ax25t_pkg::ChCr);
            if (in_frame_byte == ax25t_pkg::ChCr)
              cmd.op = crp_r ? ax25t_pkg::OP_CR : ax25t_pkg::OP_NONE;
            else begin
              cmd.op = crp_r ? ax25t_pkg::OP_CR_CHAR : ax25t_pkg::OP_CHAR;
              cmd.ch = in_frame_byte;
            end
          end
        end
        default: phase_nxt = PH_SKIP;
      endcase
      if (!busy_nxt) begin
        if (in_frame_end) begin
          if (phase_nxt != PH_PAYLOAD && phase_nxt != PH_SKIP) err_nxt = 1'b1;
          cmd.last = 1'b1;
          cmd.err = err_nxt;
          cmd.end_cr = !err_nxt && crp_nxt;
          cmd_valid = 1'b1;
        end else begin
          cmd_valid = (cmd.op != ax25t_pkg::OP_NONE);
        end
      end
    end

    if (cmd_valid && cmd.last) begin
      phase_nxt = PH_DEST; pos_nxt = '0; alen_nxt = '0; stopped_nxt = 1'b0;
      dlen_nxt = '0; curlen_nxt = '0; digi_nxt = '0; cut_nxt = 1'b0;
      crp_nxt = 1'b0; err_nxt = 1'b0;
    end
    // after source, bank swap not needed: dest bank fixed at bank_r
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DEST; pos_r <= '0; alen_r <= '0; stopped_r <= 1'b0;
      dlen_r <= '0; curlen_r <= '0; digi_r <= '0; cut_r <= 1'b0;
      crp_r <= 1'b0; err_r <= 1'b0; bank_r <= 1'b0; sfx_cnt_r <= '0;
      busy_r <= 1'b0; fin_r <= 1'b0; aph_r <= PH_DEST; star_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; alen_r <= alen_nxt;
      stopped_r <= stopped_nxt; dlen_r <= dlen_nxt; curlen_r <= curlen_nxt;
      digi_r <= digi_nxt; cut_r <= cut_nxt; crp_r <= crp_nxt; err_r <= err_nxt;
      bank_r <= bank_nxt; sfx_cnt_r <= sfx_cnt_nxt; busy_r <= busy_nxt;
      fin_r <= fin_nxt; aph_r <= aph_nxt; star_r <= star_nxt;
    end
    ssid_r <= ssid_nxt;
  end

  assign cur_len = curlen_r;
  assign dest_len = dlen_r;

endmodule

// ===== sv/ax25t_queue.sv =====
// short fifo of commands between front and back end
module ax25t_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_stall,
  input  ax25t_pkg::cmd_t wr_cmd,
  input  logic [3:0]      wr_len,
  input  logic [3:0]      wr_dlen,
  output logic            rd_valid,
  input  logic            rd_pop,
  output ax25t_pkg::cmd_t rd_cmd,
  output logic [3:0]      rd_len,
  output logic [3:0]      rd_dlen
);

  // depth one: the text store is shared, so one address command in flight
  logic            full_r;
  ax25t_pkg::cmd_t cmd_r;
  logic [3:0]      len_r, dlen_r;

  assign wr_stall = full_r;
  assign rd_valid = full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else if (wr_valid && !full_r) full_r <= 1'b1;
    else if (rd_pop) full_r <= 1'b0;
    if (wr_valid && !full_r) begin
      cmd_r <= wr_cmd; len_r <= wr_len; dlen_r <= wr_dlen;
    end
  end

  assign rd_cmd = cmd_r;
  assign rd_len = len_r;
  assign rd_dlen = dlen_r;

endmodule

// ===== sv/ax25t_back.sv =====
// back end: streams characters of one command out through an output register
module ax25t_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  ax25t_pkg::cmd_t q_cmd,
  input  logic [3:0]      q_len,
  input  logic [3:0]      q_dlen,
  output logic [4:0]      txt_raddr,
  input  logic [7:0]      txt_rdata,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_text_byte,
  output logic            out_char_valid,
  output logic            out_frame_done,
  output logic            out_frame_error
);

  // steps: S_CUR reads current bank, S_GT, S_DST reads dest bank, etc.
  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_CUR, S_GT, S_DST, S_CH, S_ENDCR, S_END
  } st_t;

  st_t        st_r;
  logic [3:0] idx_r;
  logic       rd_r;        // read data valid for emission
  logic       ov_r;
  logic [7:0] ob_r;
  logic       ocv_r, odn_r, oer_r;
  logic       ready;
  logic       bank_src;

  assign ready = !ov_r || !out_stall;
  assign bank_src = 1'b1;

  always_comb begin
    txt_raddr = {(st_r == S_DST) ? 1'b0 : bank_src, idx_r};
  end

  // emitting the trailing cr keeps the command until the end marker goes out
  assign q_pop = (st_r == S_END) && ready &&
                 !(q_cmd.last && q_cmd.end_cr && !rd_r) ||
                 (st_r == S_IDLE && q_valid && q_cmd.op == ax25t_pkg::OP_NONE &&
                  !q_cmd.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; idx_r <= '0; rd_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          idx_r <= '0; rd_r <= 1'b0;
          if (q_valid) begin
            case (q_cmd.op)
              ax25t_pkg::OP_SRC:     st_r <= S_CUR;
              ax25t_pkg::OP_DIGI:    st_r <= S_PRE;
              ax25t_pkg::OP_CHAR:    st_r <= S_CH;
              ax25t_pkg::OP_CR_CHAR,
              ax25t_pkg::OP_CR:      st_r <= S_ENDCR;
              default:               st_r <= q_cmd.last ? S_END : S_IDLE;
            endcase
          end
        end
        S_PRE: if (ready) begin
          ov_r <= 1'b1; ob_r <= ax25t_pkg::ChComma; ocv_r <= 1'b1;
          odn_r <= 1'b0; oer_r <= 1'b0; st_r <= S_CUR;
        end
        S_CUR, S_DST: begin
          // registered read: prefetch each character, then emit it once the output can take it
          if (!rd_r) begin
            if (idx_r == ((st_r == S_CUR) ? q_len : q_dlen)) begin
              if (st_r == S_CUR && q_cmd.op == ax25t_pkg::OP_SRC) st_r <= S_GT;
              else st_r <= q_cmd.last ? S_END : S_IDLE;
              if (!q_cmd.last && st_r != S_CUR) st_r <= S_IDLE;
            end else begin
              rd_r <= 1'b1;
            end
          end else if (ready) begin
            ov_r <= 1'b1; ob_r <= txt_rdata; ocv_r <= 1'b1;
            odn_r <= 1'b0; oer_r <= 1'b0;
            idx_r <= idx_r + 1'b1; rd_r <= 1'b0;
          end
          if (!rd_r && idx_r == ((st_r == S_CUR) ? q_len : q_dlen)) begin
            idx_r <= '0;
            if (st_r == S_CUR && q_cmd.op == ax25t_pkg::OP_SRC) st_r <= S_GT;
            else st_r <= S_END;
          end
        end
        S_GT: if (ready) begin
          ov_r <= 1'b1; ob_r <= ax25t_pkg::ChGt; ocv_r <= 1'b1;
          odn_r <= 1'b0; oer_r <= 1'b0; st_r <= S_DST; idx_r <= '0;
        end
        S_ENDCR: if (ready) begin
          ov_r <= 1'b1; ob_r <= ax25t_pkg::ChCr; ocv_r <= 1'b1;
          odn_r <= 1'b0; oer_r <= 1'b0;
          st_r <= (q_cmd.op == ax25t_pkg::OP_CR_CHAR) ? S_CH : S_END;
        end
        S_CH: if (ready) begin
          ov_r <= 1'b1; ob_r <= q_cmd.ch; ocv_r <= 1'b1;
          odn_r <= 1'b0; oer_r <= 1'b0; st_r <= S_END;
        end
        S_END: if (ready) begin
          // command finished: if the frame ends here, a pending cr and then the end marker
          if (q_cmd.last && q_cmd.end_cr && !rd_r) begin
            ov_r <= 1'b1; ob_r <= ax25t_pkg::ChCr; ocv_r <= 1'b1;
            odn_r <= 1'b0; oer_r <= 1'b0; rd_r <= 1'b1; st_r <= S_END;
          end else begin
            if (q_cmd.last) begin
              ov_r <= 1'b1; ob_r <= '0; ocv_r <= 1'b0;
              odn_r <= 1'b1; oer_r <= q_cmd.err;
            end
            st_r <= S_IDLE; rd_r <= 1'b0;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_text_byte = ob_r;
  assign out_char_valid = ocv_r;
  assign out_frame_done = odn_r;
  assign out_frame_error = oer_r;

endmodule

// ===== sv/ax25_frame_to_tnc2_text.sv =====
// top level: ax.25 ui frame bytes in, tnc2 monitor text out
//  channel | direction | payload
//  in_     | in        | frame_byte, frame_end
//  out_    | out       | text_byte, char_valid, frame_done, frame_error
// an address byte is written to the text store as it is accepted; after the ssid byte
// the input stalls while the suffix is written to the text store, then the back end
// streams up to nineteen characters, each from the registered text store read port.
// the input stalls while a command waits in the queue; reset clears all control
// state and either side may stall at any time without loss.
module ax25_frame_to_tnc2_text (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_frame_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_text_byte,
  output logic       out_char_valid,
  output logic       out_frame_done,
  output logic       out_frame_error
);

  ax25t_pkg::cmd_t f_cmd, q_cmd;
  logic f_valid, f_stall, q_valid, q_pop;
  logic [3:0] cur_len, dest_len, q_len, q_dlen;
  logic txt_we;
  logic [4:0] txt_waddr, txt_raddr;
  logic [7:0] txt_wdata, txt_rdata;

  ax25t_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_frame_byte, .in_frame_end,
    .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd),
    .txt_we, .txt_waddr, .txt_wdata, .cur_len, .dest_len
  );

  ax25t_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_cmd(f_cmd),
    .wr_len(cur_len), .wr_dlen(dest_len), .rd_valid(q_valid), .rd_pop(q_pop),
    .rd_cmd(q_cmd), .rd_len(q_len), .rd_dlen(q_dlen)
  );

  ax25t_ram #(.Width(8), .Depth(32)) u_txt (
    .clk, .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
    .raddr(txt_raddr), .rdata(txt_rdata)
  );

  ax25t_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .q_len, .q_dlen,
    .txt_raddr, .txt_rdata, .out_valid, .out_stall, .out_text_byte,
    .out_char_valid, .out_frame_done, .out_frame_error
  );

`ifndef SYNTHESIS
  a_done_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_char_valid) else $error("done with char");
  a_err_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error |-> out_frame_done) else $error("stray error");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
`endif

endmodule

// ===== test/tnc2_text_checker.sv =====
// checker: predicts the tnc2 text stream from accepted frame bytes and compares results
module tnc2_text_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_frame_byte,
  input  logic       in_frame_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_text_byte,
  input  logic       out_char_valid,
  input  logic       out_frame_done,
  input  logic       out_frame_error,
  output int         fail_count,
  output int         pending_count
);

  typedef enum logic [2:0] {
    PH_DEST, PH_SRC, PH_DIGI, PH_CTRL, PH_PID, PH_PAYLOAD, PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       char_valid;
    logic       frame_done;
    logic       frame_error;
  } text_item_t;

  text_item_t expected_text[$];

  phase_t     ph;
  logic [2:0] pos;
  logic [7:0] call_chars[6];
  int         call_len;
  logic       call_stopped;
  logic [7:0] dest_chars[9];
  int         dest_len;
  int         digis;
  logic       cut;
  logic       cr_held;
  logic       err_seen;

  assign pending_count = expected_text.size();

  function automatic text_item_t mk(logic [7:0] c, logic v, logic d, logic e);
    text_item_t t;
    t.text_byte = c;
    t.char_valid = v;
    t.frame_done = d;
    t.frame_error = e;
    return t;
  endfunction

  task automatic emit_char(logic [7:0] c);
    expected_text.push_back(mk(c, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic clear_frame();
    ph = PH_DEST;
    pos = 0;
    call_len = 0;
    call_stopped = 0;
    dest_len = 0;
    digis = 0;
    cut = 0;
    cr_held = 0;
    err_seen = 0;
  endtask

  task automatic reject();
    err_seen = 1;
    ph = PH_SKIP;
  endtask

  // builds the call text with ssid suffix and heard marker
  task automatic call_text(input logic [7:0] sb, input logic heard,
                           output logic [7:0] txt[10], output int n);
    logic [3:0] ssid;
    ssid = sb[4:1];
    n = 0;
    for (int i = 0; i < call_len; i++) begin
      txt[n] = call_chars[i];
      n++;
    end
    if (ssid != 0) begin
      txt[n] = ax25t_pkg::ChDash;
      n++;
      if (ssid >= 10) begin
        txt[n] = "1";
        txt[n + 1] = ax25t_pkg::ChZero + {4'd0, ssid - 4'd10};
        n += 2;
      end else begin
        txt[n] = ax25t_pkg::ChZero + {4'd0, ssid};
        n++;
      end
    end
    if (heard && sb[7]) begin
      txt[n] = ax25t_pkg::ChStar;
      n++;
    end
  endtask

  task automatic address_byte(logic [7:0] b);
    logic [7:0] txt[10];
    int         n;
    logic [7:0] c;
    if (pos < 6) begin
      c = {1'b0, b[7:1]};
      if (!call_stopped) begin
        if (c == ax25t_pkg::ChSpace || c == ax25t_pkg::ChStar) call_stopped = 1;
        else if (call_len < 6) begin
          call_chars[call_len] = c;
          call_len++;
        end
      end
      pos++;
      return;
    end
    call_text(b, ph == PH_DIGI, txt, n);
    pos = 0;
    call_len = 0;
    call_stopped = 0;
    if (ph == PH_DEST) begin
      for (int i = 0; i < n && i < 9; i++) dest_chars[i] = txt[i];
      dest_len = n > 9 ? 9 : n;
      if (b[0]) reject();
      else ph = PH_SRC;
    end else if (ph == PH_SRC) begin
      for (int i = 0; i < n; i++) emit_char(txt[i]);
      emit_char(ax25t_pkg::ChGt);
      for (int i = 0; i < dest_len; i++) emit_char(dest_chars[i]);
      ph = b[0] ? PH_CTRL : PH_DIGI;
    end else begin
      digis++;
      if (digis >= ax25t_pkg::MaxDigis) begin
        reject();
        return;
      end
      if (digis == 1 || (!cut && n > 0)) begin
        emit_char(ax25t_pkg::ChComma);
        for (int i = 0; i < n; i++) emit_char(txt[i]);
      end else if (n == 0) begin
        cut = 1;
      end
      if (b[0]) ph = PH_CTRL;
    end
  endtask

  task automatic predict_text(logic [7:0] b, logic last);
    case (ph)
      PH_DEST, PH_SRC, PH_DIGI: address_byte(b);
      PH_CTRL: if (b == ax25t_pkg::CtrlUi) ph = PH_PID; else reject();
      PH_PID: begin
        if (b == ax25t_pkg::PidNone) begin
          emit_char(ax25t_pkg::ChColon);
          ph = PH_PAYLOAD;
        end else reject();
      end
      PH_PAYLOAD: begin
        if (b == ax25t_pkg::ChLf) begin
          cr_held = 0;
          ph = PH_SKIP;
        end else begin
          if (cr_held) begin
            emit_char(ax25t_pkg::ChCr);
            cr_held = 0;
          end
          if (b == ax25t_pkg::ChCr) cr_held = 1;
          else emit_char(b);
        end
      end
      default: ph = PH_SKIP;
    endcase
    if (last) begin
      if (ph != PH_PAYLOAD && ph != PH_SKIP) err_seen = 1;
      if (!err_seen && cr_held) emit_char(ax25t_pkg::ChCr);
      expected_text.push_back(mk(8'h00, 1'b0, 1'b1, err_seen));
      clear_frame();
    end
  endtask

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_frame();
  end

  always @(posedge clk) begin
    text_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_text(in_frame_byte, in_frame_end);
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0)
          report("unexpected transaction", out_text_byte, 8'h00);
        else begin
          want = expected_text.pop_front();
          if (out_text_byte !== want.text_byte)
            report("text_byte", out_text_byte, want.text_byte);
          if (out_char_valid !== want.char_valid)
            report("char_valid", out_char_valid, want.char_valid);
          if (out_frame_done !== want.frame_done)
            report("frame_done", out_frame_done, want.frame_done);
          if (out_frame_error !== want.frame_error)
            report("frame_error", out_frame_error, want.frame_error);
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
// testbench top: frame stimulus, handshake pressure and the verdict
module testbench;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_frame_byte;
  logic       in_frame_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_text_byte;
  logic       out_char_valid;
  logic       out_frame_done;
  logic       out_frame_error;
  int         fail_count;
  int         pending_count;
  int         cycle_count;
  int         sent;
  logic       hold_off;

  logic [7:0] frame_buf[$];

  ax25_frame_to_tnc2_text dut (.*);

  tnc2_text_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall: random gaps, plus a long hold-off when asked
  initial begin
    int g;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        g = (cycle_count % 3000 < 1000) ? 0 : gap_len();
        out_stall <= (g != 0);
        repeat (g > 0 ? g : 1) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int g;
    g = (cycle_count % 3000 < 1000) ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_frame_byte <= b;
    in_frame_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
  endtask

  function automatic logic [7:0] call_ch();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return {7'($urandom_range(8'h41, 8'h5a)), 1'b0};
    if (r == 7) return {7'($urandom_range(8'h30, 8'h39)), 1'b0};
    if (r == 8) return {ax25t_pkg::ChSpace[6:0], 1'b0};
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_addr(int len, logic [3:0] ssid, logic h, logic last);
    for (int i = 0; i < 6; i++)
      frame_buf.push_back(i < len ? call_ch() : {ax25t_pkg::ChSpace[6:0], 1'b0});
    frame_buf.push_back({h, 2'($urandom_range(0, 3)), ssid, last});
  endtask

  // well-formed ui frame with random content
  task automatic build_frame(int ndig, int plen, bit crlf);
    logic [7:0] b;
    add_addr($urandom_range(0, 6), 4'($urandom_range(0, 15)),
             1'($urandom_range(0, 1)), 1'b0);
    add_addr($urandom_range(0, 6), 4'($urandom_range(0, 15)),
             1'($urandom_range(0, 1)), ndig == 0);
    for (int d = 0; d < ndig; d++)
      add_addr($urandom_range(0, 6), 4'($urandom_range(0, 15)),
               1'($urandom_range(0, 1)), d == ndig - 1);
    frame_buf.push_back(ax25t_pkg::CtrlUi);
    frame_buf.push_back(ax25t_pkg::PidNone);
    for (int i = 0; i < plen; i++) begin
      b = $urandom_range(0, 9) == 0 ? ax25t_pkg::ChCr : 8'($urandom_range(0, 255));
      if (b == ax25t_pkg::ChLf && $urandom_range(0, 1)) b = 8'h41;
      frame_buf.push_back(b);
    end
    if (crlf) begin
      frame_buf.push_back(ax25t_pkg::ChCr);
      frame_buf.push_back(ax25t_pkg::ChLf);
      frame_buf.push_back(8'h55);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    rst_n = 0;
    in_valid = 0;
    in_frame_byte = 0;
    in_frame_end = 0;
    hold_off = 0;
    cycle_count = 0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: full frame with digis and crlf, all-ones bytes, zero bytes
    build_frame(2, 3, 1);
    send_frame();
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();
    // destination marked last, bad control, bad pid
    add_addr(6, 4'hf, 1'b1, 1'b1);
    frame_buf.push_back(8'h00);
    send_frame();
    add_addr(3, 4'h0, 1'b0, 1'b0);
    add_addr(3, 4'h0, 1'b0, 1'b1);
    frame_buf.push_back(8'h13);
    send_frame();
    add_addr(3, 4'h0, 1'b0, 1'b0);
    add_addr(3, 4'h0, 1'b0, 1'b1);
    frame_buf.push_back(ax25t_pkg::CtrlUi);
    frame_buf.push_back(8'hcf);
    send_frame();
    // too many digis, empty digis cutting the path, lone cr at end
    build_frame(ax25t_pkg::MaxDigis, 1, 0);
    send_frame();
    add_addr(2, 4'h0, 1'b0, 1'b0);
    add_addr(2, 4'h0, 1'b0, 1'b0);
    add_addr(0, 4'h0, 1'b0, 1'b0);
    add_addr(0, 4'h0, 1'b0, 1'b0);
    add_addr(4, 4'h5, 1'b1, 1'b1);
    frame_buf.push_back(ax25t_pkg::CtrlUi);
    frame_buf.push_back(ax25t_pkg::PidNone);
    frame_buf.push_back(ax25t_pkg::ChCr);
    send_frame();
    drain();

    while (sent < 470) begin
      r = $urandom_range(0, 9);
      if (r < 7) build_frame($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 1));
      else if (r < 9) begin
        build_frame($urandom_range(0, ax25t_pkg::MaxDigis), $urandom_range(0, 3), 0);
        repeat ($urandom_range(1, 6)) void'(frame_buf.pop_back());
        if (frame_buf.size() == 0) frame_buf.push_back(8'($urandom_range(0, 255)));
      end else
        repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom_range(0, 255)));
      if (sent > 200 && sent <= 300) hold_off <= 1;
      if (sent > 300) hold_off <= 0;
      send_frame();
      if ($urandom_range(0, 14) == 0) drain();
    end
    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
